### design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types and constants for the subset sum checker
// ----------------------------------------------------------------------------
package ssc_pkg;

  // default largest sum tracked by the bit set
  localparam int MAX_SUM_DEF = 1023;

  // one memory word of the reachable-sums bit set
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int VALUE_W = 16;
  localparam int KIND_W  = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DRAIN,
    ST_QRY
  } state_t;

endpackage

### design/ssc_mem.sv
// ----------------------------------------------------------------------------
// ssc_mem
// bit set storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module ssc_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             wa,
  input  logic [ssc_pkg::WORD_W-1:0] wd,
  input  logic [AW-1:0]             ra,
  input  logic [AW-1:0]             rb,
  output logic [ssc_pkg::WORD_W-1:0] rda,
  output logic [ssc_pkg::WORD_W-1:0] rdb
);
  import ssc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda <= mem[ra];
    rdb <= mem[rb];
  end

endmodule

### design/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// request sequencer and shift-or datapath around the bit set memory
// ----------------------------------------------------------------------------
module ssc_ctrl #(
  parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF,
  parameter int DEPTH   = 16,
  parameter int AW      = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ssc_pkg::KIND_W-1:0]  in_kind,
  input  logic [ssc_pkg::VALUE_W-1:0] in_value,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic                        we,
  output logic [AW-1:0]               wa,
  output logic [ssc_pkg::WORD_W-1:0]  wd,
  output logic [AW-1:0]               ra,
  output logic [AW-1:0]               rb,
  input  logic [ssc_pkg::WORD_W-1:0]  rda,
  input  logic [ssc_pkg::WORD_W-1:0]  rdb
);
  import ssc_pkg::*;

  localparam int TOP_BITS = (MAX_SUM % WORD_W) + 1;
  localparam logic [WORD_W-1:0] TOP_MASK = (TOP_BITS == WORD_W) ? {WORD_W{1'b1}} :
                                           ((64'd1 << TOP_BITS) - 64'd1);
  localparam logic [AW:0]   WORDS_C  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_t state_r, state_nxt;

  logic              clean_r;
  logic [AW:0]       d_cnt_r;
  logic [AW-1:0]     ws_r;
  logic [BIT_W-1:0]  bs_r;
  logic              p_src_ok_r, p_dst_ok_r;
  logic [AW-1:0]     ra_idx_r, rb_idx_r;
  logic [WORD_W-1:0] prev_r;
  logic              q_oor_r;
  logic [BIT_W-1:0]  q_bit_r;

  logic              accept, is_add, is_qry, in_range;
  logic [AW:0]       ws_ext;
  logic              src_ok, dst_ok;
  logic [WORD_W-1:0] word_a, word_b, cur, shifted, merged;

  assign in_range = ({16'd0, in_value} <= 32'(MAX_SUM));
  assign accept   = start && (state_r == ST_IDLE);
  assign is_add   = (in_kind == KIND_ADD) && (in_value != '0) && in_range;
  assign is_qry   = (in_kind == KIND_QUERY);
  assign ws_ext   = {1'b0, ws_r};

  // read issue: source word d-ws-1 on port a, destination word d on port b
  assign src_ok = (state_r == ST_ADD) && (d_cnt_r > ws_ext);
  assign dst_ok = (state_r == ST_ADD) && (d_cnt_r != WORDS_C);
  assign ra     = AW'(d_cnt_r - ws_ext - (AW+1)'(1));
  assign rb     = (state_r == ST_IDLE) ? in_value[BIT_W+AW-1:BIT_W] : d_cnt_r[AW-1:0];

  // a set with no add since clear reads as {0}
  assign word_a = clean_r ? ((ra_idx_r == '0) ? 64'd1 : 64'd0) : rda;
  assign word_b = clean_r ? ((rb_idx_r == '0) ? 64'd1 : 64'd0) : rdb;

  assign cur     = p_src_ok_r ? word_a : '0;
  assign shifted = (prev_r << bs_r) |
                   ((bs_r == '0) ? '0 : (cur >> (7'd64 - {1'b0, bs_r})));
  assign merged  = (rb_idx_r == LAST_IDX) ? ((word_b | shifted) & TOP_MASK)
                                          : (word_b | shifted);

  assign we = p_dst_ok_r;
  assign wa = rb_idx_r;
  assign wd = merged;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_add) begin
          state_nxt = ST_ADD;
        end else if (accept && is_qry) begin
          state_nxt = ST_QRY;
        end
      end
      ST_ADD: begin
        if (d_cnt_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_QRY:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != ST_IDLE);
    out_strobe = (state_r == ST_QRY);
    out_found  = !q_oor_r && word_b[q_bit_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clean_r    <= 1'b1;
      p_dst_ok_r <= 1'b0;
      p_src_ok_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p_dst_ok_r <= dst_ok;
      p_src_ok_r <= src_ok;
      if (accept && (in_kind == KIND_CLEAR)) begin
        clean_r <= 1'b1;
      end else if (state_r == ST_DRAIN) begin
        clean_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_idx_r <= ra;
    rb_idx_r <= rb;
    prev_r   <= cur;
    if (accept) begin
      ws_r    <= in_value[BIT_W+AW-1:BIT_W];
      bs_r    <= in_value[BIT_W-1:0];
      d_cnt_r <= WORDS_C;
      q_oor_r <= !in_range;
      q_bit_r <= in_value[BIT_W-1:0];
    end else if (state_r == ST_ADD) begin
      d_cnt_r <= d_cnt_r - (AW+1)'(1);
    end
  end

`ifndef ASSERT_OFF
  a_strobe_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && (in_kind == KIND_QUERY)))
    else $error("result strobe without a query request");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (wa <= LAST_IDX))
    else $error("write beyond the last word");

  a_write_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (we && $past(we)) |-> (wa == $past(wa) - AW'(1)))
    else $error("add sweep does not descend one word a cycle");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> ($past(state_r) == ST_DRAIN || $past(state_r) == ST_QRY))
    else $error("busy dropped mid request");
`endif

endmodule

### design/subset_sum_checker.sv
// ----------------------------------------------------------------------------
// subset_sum_checker
// reachable-sums bit set held in a word memory, updated by add requests
// ----------------------------------------------------------------------------
// latency: a query result strobes in the cycle after the request is taken
// busy: a query stays busy in its result state and a clear never raises it;
//   an add stays busy for its one-word-a-cycle read-modify-write sweep
// out-of-range and zero adds and unused kinds never raise busy
// reset: synchronous, the set reads as {0} at once, memory is not swept
// results cannot be stalled: out_strobe is high for exactly one cycle
module subset_sum_checker #(
  parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ssc_pkg::KIND_W-1:0]  in_kind,
  input  logic [ssc_pkg::VALUE_W-1:0] in_value,
  output logic                        out_strobe,
  output logic                        out_found
);
  import ssc_pkg::*;

  // number of 64-bit words covering sums 0..MAX_SUM
  localparam int DEPTH = (MAX_SUM / WORD_W) + 1;
  // word address width, at least one bit
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // memory port wiring
  logic              we;
  logic [AW-1:0]     wa, ra, rb;
  logic [WORD_W-1:0] wd, rda, rdb;

  // sequencer: an add sweeps from the top word down, reading the source
  // word on port a and the destination word on port b, and writes the
  // merged word in the following cycle; writes never hit a word still to be read
  ssc_ctrl #(
    .MAX_SUM (MAX_SUM),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_found  (out_found),
    .we         (we),
    .wa         (wa),
    .wd         (wd),
    .ra         (ra),
    .rb         (rb),
    .rda        (rda),
    .rdb        (rdb)
  );

  // bit set storage, registered reads on both ports
  ssc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra),
    .rb  (rb),
    .rda (rda),
    .rdb (rdb)
  );

endmodule

### tb/subset_sum_checker_tb.sv
// ----------------------------------------------------------------------------
// subset_sum_checker_tb
// drives clear, add, query and unused-kind requests into the subset sum
// checker, tracks the reachable-sums set alongside it and checks every found strobe in order
// ----------------------------------------------------------------------------
module subset_sum_checker_tb;
  import ssc_pkg::*;

  localparam int MAX_SUM = MAX_SUM_DEF;
  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // random requests after the directed part
  localparam int RANDOM_ITEMS = 1625;
  // an add sweeps the memory one word a cycle, so allow that plus margin
  localparam int TAIL_CYCLES = MAX_SUM / 64 + 8;
  // cycles with neither a request taken nor a result seen
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [VALUE_W-1:0] target;
    logic               found;
  } answer_t;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic [KIND_W-1:0]  in_kind  = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               busy;
  logic               out_strobe;
  logic               out_found;

  // mirror of the block's reachable-sums bit set
  logic [MAX_SUM:0]   sum_set;
  answer_t            pending_answers[$];
  int                 error_count = 0;
  int                 quiet_cycles = 0;
  // when set, requests go out back to back with no idle cycles
  bit                 burst_mode = 1'b0;

  subset_sum_checker #(.MAX_SUM(MAX_SUM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_found  (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // update the mirrored set for one taken request, queue the answer of a query
  function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] value);
    answer_t ans;
    case (kind)
      KIND_CLEAR: sum_set = {{MAX_SUM{1'b0}}, 1'b1};
      KIND_ADD: begin
        // zero and out-of-range elements leave the set alone
        if (value != 0 && value <= MAX_SUM)
          sum_set = sum_set | (sum_set << value);
      end
      KIND_QUERY: begin
        ans.target = value;
        ans.found  = (value <= MAX_SUM) ? sum_set[value] : 1'b0;
        pending_answers.push_back(ans);
      end
      default: ;  // unused kind: no state change, no answer
    endcase
  endfunction

  // element values: mostly small so subsets fill the set, some extremes
  function automatic logic [VALUE_W-1:0] pick_element();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)      return '0;
    else if (r == 1) return VALUE_W'($urandom_range(MAX_SUM + 1, 65535));
    else if (r == 2) return VALUE_W'(MAX_SUM);
    else if (r == 3) return VALUE_W'($urandom);
    else if (r < 10) return VALUE_W'($urandom_range(1, 15));
    else             return VALUE_W'($urandom_range(1, MAX_SUM / 4));
  endfunction

  // targets: often a sum known to be reachable so found=1 shows up too
  function automatic logic [VALUE_W-1:0] pick_target();
    int r;
    int t;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return VALUE_W'($urandom_range(MAX_SUM + 1, 65535));
    if (r == 2) return VALUE_W'($urandom);
    if (r < 6)  return VALUE_W'($urandom_range(0, 63));
    if (r < 12) begin
      for (int i = 0; i < 8; i++) begin
        t = $urandom_range(0, MAX_SUM);
        if (sum_set[t]) return VALUE_W'(t);
      end
    end
    return VALUE_W'($urandom_range(0, MAX_SUM));
  endfunction

  // send one request and wait until the block takes it; start is left high
  // so a following request can go out in the very next cycle
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [VALUE_W-1:0] value);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) gap = 0;
    else if (r < 85)          gap = $urandom_range(1, 3);
    else if (r < 97)          gap = $urandom_range(4, 10);
    else                      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      // idle with junk on the payload
      start    <= 1'b0;
      in_kind  <= KIND_W'($urandom);
      in_value <= VALUE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    predict_request(kind, value);
  endtask

  // drop start and hold off until every queued answer has come back
  task automatic wait_for_answers();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // results cannot be held off: compare every strobe with the oldest answer
  always @(posedge clk) begin
    answer_t ans;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found=%0b",
                   $time, out_found);
          error_count++;
        end else begin
          ans = pending_answers.pop_front();
          if (out_found !== ans.found) begin
            $display("%0t: found for target %0d: expected %0b, actual %0b",
                     $time, ans.target, ans.found, out_found);
            error_count++;
          end
        end
      end else if (out_strobe !== 1'b0) begin
        $display("%0t: out_strobe: expected 0 or 1, actual %b", $time, out_strobe);
        error_count++;
      end
    end
  end

  // watchdog: ends a run that stops making progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // the set after reset is {0}
  task automatic test_reset_state();
    send_request(KIND_QUERY, 16'd0);
    send_request(KIND_QUERY, 16'd1);
    send_request(KIND_QUERY, VALUE_W'(MAX_SUM));
  endtask

  // zero and oversized elements change nothing, oversized targets miss
  task automatic test_out_of_range();
    send_request(KIND_ADD, 16'd0);
    send_request(KIND_ADD, VALUE_W'(MAX_SUM + 1));
    send_request(KIND_ADD, 16'hffff);
    send_request(KIND_QUERY, 16'hffff);
    send_request(KIND_QUERY, VALUE_W'(MAX_SUM + 1));
    send_request(KIND_QUERY, 16'd0);
    send_request(KIND_QUERY, 16'd1);
  endtask

  // largest element: the top sum is set, the sum past the top is dropped
  task automatic test_add_extremes();
    send_request(KIND_ADD, 16'd1);
    send_request(KIND_ADD, VALUE_W'(MAX_SUM));
    send_request(KIND_QUERY, VALUE_W'(MAX_SUM));
    send_request(KIND_QUERY, 16'd1);
    send_request(KIND_QUERY, 16'd2);
  endtask

  // unused kind is taken but leaves the set and the result side alone
  task automatic test_unused_kind();
    send_request(KIND_UNUSED, 16'hffff);
    send_request(KIND_UNUSED, 16'd3);
    send_request(KIND_QUERY, 16'd1);
  endtask

  // clear ignores its value and goes back to {0}
  task automatic test_clear();
    send_request(KIND_CLEAR, 16'hffff);
    send_request(KIND_QUERY, 16'd1);
    send_request(KIND_QUERY, 16'd0);
    send_request(KIND_ADD, 16'd5);
    send_request(KIND_ADD, 16'd7);
    send_request(KIND_QUERY, 16'd12);
    send_request(KIND_QUERY, 16'd2);
  endtask

  // mostly clear-then-build sequences with random content, some noise
  task automatic test_random_sequences();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any kind, any value
        send_request(KIND_W'($urandom), VALUE_W'($urandom));
        sent++;
      end else begin
        // clear is sometimes skipped so sets build up across sequences
        if ($urandom_range(0, 3) != 0) begin
          send_request(KIND_CLEAR, VALUE_W'($urandom));
          sent++;
        end
        len = $urandom_range(2, 16);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 19);
          if (r < 9)       send_request(KIND_ADD, pick_element());
          else if (r < 19) send_request(KIND_QUERY, pick_target());
          else             send_request(KIND_UNUSED, VALUE_W'($urandom));
          sent++;
        end
      end
      // now and then hold off until the block has answered everything
      if ($urandom_range(0, 11) == 0) wait_for_answers();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    sum_set = {{MAX_SUM{1'b0}}, 1'b1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_mode = 1'b1;
    test_reset_state();
    burst_mode = 1'b0;
    test_out_of_range();
    burst_mode = 1'b1;
    test_add_extremes();
    burst_mode = 1'b0;
    test_unused_kind();
    wait_for_answers();
    test_clear();
    test_random_sequences();

    // drain, then give a last add sweep time to show any stray strobe
    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
design/ssc_pkg.sv
design/ssc_mem.sv
design/ssc_ctrl.sv
design/subset_sum_checker.sv
tb/subset_sum_checker_tb.sv
